>>> rtl/sssp_pkg.sv
`timescale 1ns / 1ps

package sssp_pkg;

    localparam int PWM_PERIOD_TICKS = 100;
    localparam int TICKS_PER_SECOND = 1000;
    localparam int PCT_MAX          = 100;
    localparam int FULL_SPEED       = 255;

    localparam int PCT_W     = 7;
    localparam int SECS_W    = 16;
    localparam int ELAPSED_W = 26;
    localparam int PROD_W    = ELAPSED_W + PCT_W;
    localparam int CNT_W     = $clog2(PCT_W);
    localparam int PHASE_W   = 7;
    localparam int SPEED_W   = 16;
    localparam int MAG_W     = 15;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_DRIVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SECS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_RIGHT = 2'd3;

endpackage

>>> rtl/sssp_duty.sv
`timescale 1ns / 1ps

module sssp_duty (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [sssp_pkg::ELAPSED_W-1:0]   i_elapsed,
    input  logic [sssp_pkg::ELAPSED_W-1:0]   i_len,
    input  logic [sssp_pkg::PCT_W-1:0]       i_span,
    output logic                             o_done,
    output logic [sssp_pkg::PCT_W-1:0]       o_quot
);
    import sssp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   r_mcand;
    logic [PROD_W-1:0]   r_div;
    logic [PCT_W-1:0]    r_mplier;
    logic [PCT_W-1:0]    r_quot;
    logic                r_done;
    logic                w_fits;

    assign w_fits = (r_prod >= r_div);

    // The product is built one multiplier bit per cycle, then the quotient
    // is found one bit per cycle by restoring division.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_prod   <= '0;
                        r_mcand  <= {{PCT_W{1'b0}}, i_elapsed};
                        r_div    <= {1'b0, i_len, {(PCT_W-1){1'b0}}};
                        r_mplier <= i_span;
                        r_cnt    <= CNT_W'(PCT_W-1);
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_prod <= r_prod + r_mcand;
                    end
                    r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[PCT_W-1:1]};
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(PCT_W-1);
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DIV: begin
                    if (w_fits) begin
                        r_prod <= r_prod - r_div;
                    end
                    r_quot <= {r_quot[PCT_W-2:0], w_fits};
                    r_div  <= {1'b0, r_div[PROD_W-1:1]};
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/soft_start_spin_pwm.sv
`timescale 1ns / 1ps
// A direct drive item gives its result in the cycle after acceptance. A ramp tick passes
// through S_LEN, S_EL and S_CALC; if clamped max duty is above clamped min duty it waits in
// S_WAIT while the duty unit does a shift-add multiply and a restoring divide, else its
// result is registered from S_CALC. Items are taken only in S_IDLE with the output register
// empty or being read, so no new item is taken while a ramp tick is in work.
// Reset is synchronous and active low: spinning stops, counters clear, settings load defaults.

module soft_start_spin_pwm (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [sssp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sssp_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [sssp_pkg::OP_W-1:0]             i_opcode,
    input  logic signed [sssp_pkg::SPEED_W-1:0]   i_left_speed,
    input  logic signed [sssp_pkg::SPEED_W-1:0]   i_right_speed,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [sssp_pkg::MAG_W-1:0]            o_left_magnitude,
    output logic                                  o_left_reverse,
    output logic [sssp_pkg::MAG_W-1:0]            o_right_magnitude,
    output logic                                  o_right_reverse,
    output logic [sssp_pkg::PCT_W-1:0]            o_ramp_duty
);
    import sssp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_LEN, S_EL, S_CALC, S_WAIT} t_state;

    t_state               r_state;
    logic [PCT_W-1:0]     r_min_duty;
    logic [PCT_W-1:0]     r_max_duty;
    logic [SECS_W-1:0]    r_ramp_secs;
    logic                 r_spin_right;
    logic                 r_spin;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [ELAPSED_W-1:0] r_len;
    logic [ELAPSED_W-1:0] r_el;
    logic [PHASE_W-1:0]   r_phase;
    logic [PCT_W-1:0]     r_lo;
    logic [PCT_W-1:0]     r_hi;
    logic                 r_div_start;
    logic                 r_out_valid;
    logic [MAG_W-1:0]     r_left_mag;
    logic                 r_left_rev;
    logic [MAG_W-1:0]     r_right_mag;
    logic                 r_right_rev;
    logic [PCT_W-1:0]     r_duty;

    logic                 w_accept;
    logic                 w_div_done;
    logic [PCT_W-1:0]     w_quot;
    logic [PHASE_W-1:0]   n_phase;
    logic [ELAPSED_W-1:0] n_elapsed;
    logic [ELAPSED_W-1:0] n_el;
    logic [SECS_W-1:0]    w_secs;
    logic [PCT_W-1:0]     n_duty;
    logic [MAG_W-1:0]     n_speed;
    logic [SPEED_W-1:0]   w_left_abs;
    logic [SPEED_W-1:0]   w_right_abs;

    function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] v);
        return (v > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : v;
    endfunction

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    assign n_phase = (r_phase == PHASE_W'(PWM_PERIOD_TICKS - 1)) ? '0 : r_phase + 1'b1;
    assign w_secs  = (r_ramp_secs == '0) ? SECS_W'(1) : r_ramp_secs;

    assign n_elapsed = (r_elapsed < r_len) ? r_elapsed + 1'b1 : r_elapsed;
    assign n_el      = (n_elapsed < r_len) ? n_elapsed : r_len;

    assign n_duty  = (r_state == S_WAIT) ? r_lo + w_quot : r_hi;
    assign n_speed = ({1'b0, r_phase} < {1'b0, n_duty}) ? MAG_W'(FULL_SPEED) : '0;

    assign w_left_abs  = i_left_speed[SPEED_W-1]  ? SPEED_W'(-i_left_speed)  : i_left_speed;
    assign w_right_abs = i_right_speed[SPEED_W-1] ? SPEED_W'(-i_right_speed) : i_right_speed;

    sssp_duty u_duty (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_elapsed (r_el),
        .i_len     (r_len),
        .i_span    (r_hi - r_lo),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_min_duty   <= '0;
            r_max_duty   <= PCT_W'(PCT_MAX);
            r_ramp_secs  <= SECS_W'(1);
            r_spin_right <= 1'b0;
            r_spin       <= 1'b0;
            r_elapsed    <= '0;
            r_phase      <= '0;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MIN_DUTY:   r_min_duty   <= i_cfg_data[PCT_W-1:0];
                    CFG_MAX_DUTY:   r_max_duty   <= i_cfg_data[PCT_W-1:0];
                    CFG_RAMP_SECS:  r_ramp_secs  <= i_cfg_data[SECS_W-1:0];
                    CFG_SPIN_RIGHT: r_spin_right <= i_cfg_data[0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_opcode)
                            OP_TICK: begin
                                r_phase <= n_phase;
                                if (r_spin) begin
                                    r_state <= S_LEN;
                                end
                            end
                            OP_START: begin
                                if (!r_spin) begin
                                    r_spin    <= 1'b1;
                                    r_elapsed <= '0;
                                end
                            end
                            OP_DRIVE: begin
                                r_spin      <= 1'b0;
                                r_left_mag  <= w_left_abs[SPEED_W-1] ? '1
                                                                     : w_left_abs[MAG_W-1:0];
                                r_left_rev  <= i_left_speed[SPEED_W-1];
                                r_right_mag <= w_right_abs[SPEED_W-1] ? '1
                                                                      : w_right_abs[MAG_W-1:0];
                                r_right_rev <= i_right_speed[SPEED_W-1];
                                r_duty      <= '0;
                                r_out_valid <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LEN: begin
                    r_len   <= ELAPSED_W'(w_secs * TICKS_PER_SECOND);
                    r_state <= S_EL;
                end
                S_EL: begin
                    r_elapsed <= n_elapsed;
                    r_el      <= n_el;
                    r_lo      <= clamp_pct(r_min_duty);
                    r_hi      <= clamp_pct(r_max_duty);
                    r_state   <= S_CALC;
                end
                S_CALC: begin
                    if (r_hi > r_lo) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_WAIT;
                    end else begin
                        r_left_mag  <= n_speed;
                        r_right_mag <= n_speed;
                        r_left_rev  <= !r_spin_right;
                        r_right_rev <= r_spin_right;
                        r_duty      <= n_duty;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_WAIT: begin
                    if (w_div_done) begin
                        r_left_mag  <= n_speed;
                        r_right_mag <= n_speed;
                        r_left_rev  <= !r_spin_right;
                        r_right_rev <= r_spin_right;
                        r_duty      <= n_duty;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_left_magnitude  = r_left_mag;
    assign o_left_reverse    = r_left_rev;
    assign o_right_magnitude = r_right_mag;
    assign o_right_reverse   = r_right_rev;
    assign o_ramp_duty       = r_duty;

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_ramp_duty <= PCT_W'(PCT_MAX))
        else $error("ramp duty above full scale");

    a_spin_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ramp_duty != '0) |->
            (o_left_magnitude == o_right_magnitude && o_left_reverse != o_right_reverse))
        else $error("spin result does not drive the motors in opposite directions");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_WAIT)
        else $error("duty unit finished while no ramp item was in work");

    a_start_from_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> $past(r_state) == S_CALC)
        else $error("duty unit started outside the calculation step");

endmodule
